FILE: src/imuca_pkg.sv
// ----------------------------------------------------------------------------
// imuca_pkg
// Shared constants, types and the arctangent table of the attitude estimator.
// ----------------------------------------------------------------------------
package imuca_pkg;

	// parameter defaults
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 18;

	// datapath widths
	localparam int CW  = 40;	// cordic x/y
	localparam int ZW  = 36;	// cordic angle, q30
	localparam int AW  = 32;	// angle arithmetic
	localparam int MW  = 44;	// angle reduction
	localparam int PW  = 34;	// multiplier operand
	localparam int MODK = 8;	// top shift of the 2*pi reduction

	// q30 constants
	localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ZW-1:0] GAIN_Q30    = 36'sd652032875;

	// register indexes
	localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [1:0] REG_BLEND_ALPHA   = 2'd1;
	localparam logic [1:0] REG_CALIB_COUNT   = 2'd2;

	typedef struct packed {
		logic start;
		logic rotate;
	} cordic_cmd_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		begin
			case (i)
				5'd0:  v = 36'sd843314857;
				5'd1:  v = 36'sd497837829;
				5'd2:  v = 36'sd263043837;
				5'd3:  v = 36'sd133525159;
				5'd4:  v = 36'sd67021687;
				5'd5:  v = 36'sd33543516;
				5'd6:  v = 36'sd16775851;
				5'd7:  v = 36'sd8388437;
				5'd8:  v = 36'sd4194283;
				5'd9:  v = 36'sd2097149;
				5'd10: v = 36'sd1048576;
				5'd11: v = 36'sd524288;
				5'd12: v = 36'sd262144;
				5'd13: v = 36'sd131072;
				5'd14: v = 36'sd65536;
				5'd15: v = 36'sd32768;
				5'd16: v = 36'sd16384;
				5'd17: v = 36'sd8192;
				5'd18: v = 36'sd4096;
				5'd19: v = 36'sd2048;
				5'd20: v = 36'sd1024;
				5'd21: v = 36'sd512;
				5'd22: v = 36'sd256;
				5'd23: v = 36'sd128;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

FILE: src/imuca_if.sv
// ----------------------------------------------------------------------------
// imuca_if
// Sample and attitude channels of the attitude estimator.
// ----------------------------------------------------------------------------
interface imuca_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [17:0] gyro_x;
	logic signed [17:0] gyro_y;
	logic signed [17:0] gyro_z;

	modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		output ready);
endinterface

interface imuca_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [18:0] rate_x;
	logic signed [18:0] rate_y;
	logic signed [18:0] rate_z;
	logic signed [15:0] lin_x;
	logic signed [15:0] lin_y;
	logic signed [15:0] lin_z;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z,
		lin_x, lin_y, lin_z, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z,
		lin_x, lin_y, lin_z, output ready);
endinterface

FILE: src/imu_complementary_attitude.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude
// Six-axis complementary-filter attitude estimator with quaternion output.
// ----------------------------------------------------------------------------
// usage
//  sample_in takes one accelerometer and gyro sample per transfer, attitude_out
//  gives one quaternion with the bias-corrected rates and the raw acceleration.
//  cfg_wr_en/cfg_index/cfg_wdata write sample_period, blend_alpha, calib_count;
//  write only while the block is idle.
//  after reset the first calib_count samples (one if calib_count is zero) give
//  no transfer on attitude_out; the last of them runs a bit-serial divide of the
//  gyro sums, one axis after another, before the next sample is taken.
//  every later sample runs a 32-step square root, up to five passes through the
//  one iterative cordic unit (two atan2, skipped for a zero vector, three
//  sin/cos) with a 9-step angle reduction before each rotation, and 21 uses of
//  the one shared multiplier.
//  sample_in.ready is high only while the sequencer is idle. the result is
//  held in an output register, so a stalled receiver does not stop the next
//  sample from being taken; a finished result waits only if the previous one
//  has not been transferred yet.
//  reset clears the bias, the angles and the calibration count and restores
//  the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module imu_complementary_attitude #(
	parameter int CORDIC_STEPS    = imuca_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = imuca_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	imuca_in_if.sink    sample_in,
	imuca_out_if.source attitude_out,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);
	localparam int F   = ANGLE_FRAC_BITS;
	localparam int ASH = 30 - F;	// q30 to angle format
	localparam int ISH = 36 - F;	// rate*period to angle format
	localparam int HSH = 29 - F;	// angle format to q30 half angle
	localparam int AW  = imuca_pkg::AW;
	localparam int CW  = imuca_pkg::CW;
	localparam int ZW  = imuca_pkg::ZW;
	localparam int MW  = imuca_pkg::MW;
	localparam int PW  = imuca_pkg::PW;

	localparam logic signed [ZW-1:0] PI_F_Z =
		(imuca_pkg::PI_Q30 + (36'sd1 <<< (ASH - 1))) >>> ASH;
	localparam logic signed [ZW-1:0] TWO_PI_F_Z =
		(imuca_pkg::TWO_PI_Q30 + (36'sd1 <<< (ASH - 1))) >>> ASH;
	localparam logic signed [AW-1:0] PI_F     = PI_F_Z[AW-1:0];
	localparam logic signed [AW-1:0] TWO_PI_F = TWO_PI_F_Z[AW-1:0];

	typedef enum logic [4:0] {
		S_IDLE, S_CAL_LOAD, S_CAL_DIV, S_CAL_STORE,
		S_SQ_A, S_SQ_B, S_SQ_C, S_SQRT,
		S_ROLL_GO, S_ROLL_WAIT, S_PIT_GO, S_PIT_WAIT,
		S_INT_X, S_INT_Y, S_INT_Z, S_INT_W,
		S_BR1, S_BR2, S_BR3, S_BP1, S_BP2, S_BP3,
		S_HS_LOAD, S_HS_MOD, S_HS_GO, S_HS_WAIT,
		S_QM, S_QOUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [23:0] sample_period_q;
	logic [16:0] blend_alpha_q;
	logic [15:0] calib_count_q;

	// calibration and filter state
	logic signed [33:0] bias_sum_x_q, bias_sum_y_q, bias_sum_z_q;
	logic [15:0] calib_seen_q;
	logic signed [17:0] bias_x_q, bias_y_q, bias_z_q;
	logic ready_q;
	logic signed [23:0] roll_q, pitch_q, yaw_q;

	// sample being worked on
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [18:0] gx_q, gy_q, gz_q;

	// divider
	logic [1:0]  dv_axis_q;
	logic [5:0]  dv_cnt_q;
	logic [16:0] rem_q;
	logic [33:0] quo_q;
	logic        dv_neg_q;
	logic [16:0] dv_t;

	// square root
	logic [31:0] sq_q;
	logic [63:0] rad_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic [33:0] s_t, s_trial;

	// angles
	logic signed [AW-1:0] r_acc_q, p_acc_q, rg_q, pg_q, yw_q;
	logic signed [67:0] acc_q;

	// half-angle sin/cos
	logic [1:0]  hk_q;
	logic [3:0]  kk_q;
	logic [MW-1:0] mag_q;
	logic        mneg_q, hneg_q;
	logic signed [PW-1:0] c_q [0:2];
	logic signed [PW-1:0] s_q [0:2];

	// quaternion products
	logic [3:0] qs_q;
	logic signed [PW-1:0] t_q [0:11];

	// output register
	logic ov_q;
	logic signed [15:0] qx_o, qy_o, qz_o, qw_o;

	// shared multiplier
	logic signed [PW-1:0] mul_a, mul_b;
	logic signed [67:0] prod_q;

	// cordic unit
	imuca_pkg::cordic_cmd_t cmd;
	logic signed [CW-1:0] cx0, cy0, cx, cy;
	logic signed [ZW-1:0] cz0, cz;
	logic cdone;

	imuca_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.x0(cx0), .y0(cy0), .z0(cz0),
		.x(cx), .y(cy), .z(cz), .done(cdone)
	);

	// effective blend weight, values above one act as one
	logic signed [PW-1:0] alpha, alpha_c;
	assign alpha   = (blend_alpha_q > 17'd65536) ? PW'(65536) : PW'({1'b0, blend_alpha_q});
	assign alpha_c = PW'(65536) - alpha;

	function automatic logic signed [23:0] sat24(input logic signed [67:0] v);
		logic signed [23:0] r;
		begin
			if (v < -68'sd8388608)
				r = -24'sd8388608;
			else if (v > 68'sd8388607)
				r = 24'sd8388607;
			else
				r = v[23:0];
			return r;
		end
	endfunction

	function automatic logic signed [15:0] q14(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] r;
		logic signed [15:0] o;
		begin
			r = (v + PW'(32768)) >>> 16;
			if (r < -PW'(16384))
				o = -16'sd16384;
			else if (r > PW'(16384))
				o = 16'sd16384;
			else
				o = r[15:0];
			return o;
		end
	endfunction

	// rounding of the registered product
	logic signed [67:0] inc_w, blend_w, mq_w;
	assign inc_w   = (prod_q + (68'sd1 <<< (ISH - 1))) >>> ISH;
	assign blend_w = (acc_q + prod_q + 68'sd32768) >>> 16;
	assign mq_w    = (prod_q + (68'sd1 <<< 29)) >>> 30;

	// divider step
	assign dv_t = {rem_q[15:0], quo_q[33]};

	// square root step, two radicand bits a cycle
	assign s_t     = {srem_q[31:0], rad_q[63:62]};
	assign s_trial = {root_q, 2'b01};

	// yaw wrap, once each way
	logic signed [AW-1:0] yw1, yw2;
	assign yw1 = (yw_q > PI_F) ? yw_q - TWO_PI_F : yw_q;
	assign yw2 = (yw1 < -PI_F) ? yw1 + TWO_PI_F : yw1;

	// atan2 operands and pre-rotation by pi for a negative x
	logic signed [CW-1:0] at_x, at_y;
	logic at_zero;
	always_comb begin
		if (state_q == S_ROLL_GO) begin
			at_y = CW'(ay_q) <<< 16;
			at_x = CW'(az_q) <<< 16;
		end else begin
			at_y = -(CW'(ax_q) <<< 16);
			at_x = CW'({1'b0, root_q});
		end
	end
	assign at_zero = (at_x == '0) && (at_y == '0);

	// half-angle reduction into the cordic range
	logic signed [ZW-1:0] hr0, hr1, hr2, hr3;
	logic hfold;
	logic [MW-1:0] mod_sub;
	logic signed [AW-1:0] hs_ang;
	logic signed [MW-1:0] hs_v;
	assign mod_sub = MW'(imuca_pkg::TWO_PI_Q30) << kk_q;
	always_comb begin
		case (hk_q)
			2'd0: hs_ang = AW'(roll_q);
			2'd1: hs_ang = AW'(pitch_q);
			default: hs_ang = AW'(yaw_q);
		endcase
		hs_v = MW'(hs_ang) <<< HSH;
		hr0 = mneg_q ? -$signed(mag_q[ZW-1:0]) : $signed(mag_q[ZW-1:0]);
		hr1 = (hr0 > imuca_pkg::PI_Q30) ? hr0 - imuca_pkg::TWO_PI_Q30 : hr0;
		hr2 = (hr1 < -imuca_pkg::PI_Q30) ? hr1 + imuca_pkg::TWO_PI_Q30 : hr1;
		hfold = 1'b0;
		hr3 = hr2;
		if (hr2 > imuca_pkg::HALF_PI_Q30) begin
			hr3 = hr2 - imuca_pkg::PI_Q30;
			hfold = 1'b1;
		end else if (hr2 < -imuca_pkg::HALF_PI_Q30) begin
			hr3 = hr2 + imuca_pkg::PI_Q30;
			hfold = 1'b1;
		end
	end

	// cordic launch
	always_comb begin
		cmd.start  = 1'b0;
		cmd.rotate = 1'b0;
		cx0 = at_x;
		cy0 = at_y;
		cz0 = '0;
		case (state_q)
			S_ROLL_GO, S_PIT_GO: begin
				cmd.start = !at_zero;
				if (at_x < 0) begin
					cx0 = -at_x;
					cy0 = -at_y;
					cz0 = (at_y >= 0) ? imuca_pkg::PI_Q30 : -imuca_pkg::PI_Q30;
				end
			end
			S_HS_GO: begin
				cmd.start  = 1'b1;
				cmd.rotate = 1'b1;
				cx0 = CW'(imuca_pkg::GAIN_Q30);
				cy0 = '0;
				cz0 = hr3;
			end
			default: ;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ_A:  begin mul_a = PW'(ay_q); mul_b = PW'(ay_q); end
			S_SQ_B:  begin mul_a = PW'(az_q); mul_b = PW'(az_q); end
			S_INT_X: begin mul_a = PW'(gx_q); mul_b = PW'({1'b0, sample_period_q}); end
			S_INT_Y: begin mul_a = PW'(gy_q); mul_b = PW'({1'b0, sample_period_q}); end
			S_INT_Z: begin mul_a = PW'(gz_q); mul_b = PW'({1'b0, sample_period_q}); end
			S_BR1:   begin mul_a = alpha;   mul_b = PW'(rg_q); end
			S_BR2:   begin mul_a = alpha_c; mul_b = PW'(r_acc_q); end
			S_BP1:   begin mul_a = alpha;   mul_b = PW'(pg_q); end
			S_BP2:   begin mul_a = alpha_c; mul_b = PW'(p_acc_q); end
			S_QM: begin
				case (qs_q)
					4'd0:  begin mul_a = c_q[0]; mul_b = c_q[1]; end
					4'd1:  begin mul_a = s_q[0]; mul_b = s_q[1]; end
					4'd2:  begin mul_a = s_q[0]; mul_b = c_q[1]; end
					4'd3:  begin mul_a = c_q[0]; mul_b = s_q[1]; end
					4'd4:  begin mul_a = t_q[0]; mul_b = c_q[2]; end
					4'd5:  begin mul_a = t_q[1]; mul_b = s_q[2]; end
					4'd6:  begin mul_a = t_q[2]; mul_b = c_q[2]; end
					4'd7:  begin mul_a = t_q[3]; mul_b = s_q[2]; end
					4'd8:  begin mul_a = t_q[3]; mul_b = c_q[2]; end
					4'd9:  begin mul_a = t_q[2]; mul_b = s_q[2]; end
					4'd10: begin mul_a = t_q[0]; mul_b = s_q[2]; end
					4'd11: begin mul_a = t_q[1]; mul_b = c_q[2]; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// quaternion sums
	assign qw_o = q14(t_q[4] + t_q[5]);
	assign qx_o = q14(t_q[6] - t_q[7]);
	assign qy_o = q14(t_q[8] + t_q[9]);
	assign qz_o = q14(t_q[10] - t_q[11]);

	logic [16:0] seen_nx, lim;
	assign seen_nx = {1'b0, calib_seen_q} + 17'd1;
	assign lim = (calib_count_q == '0) ? 17'd1 : {1'b0, calib_count_q};

	assign sample_in.ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			sample_period_q <= 24'd167772;
			blend_alpha_q   <= 17'd64225;
			calib_count_q   <= 16'd200;
			bias_sum_x_q    <= '0;
			bias_sum_y_q    <= '0;
			bias_sum_z_q    <= '0;
			calib_seen_q    <= '0;
			bias_x_q        <= '0;
			bias_y_q        <= '0;
			bias_z_q        <= '0;
			ready_q         <= 1'b0;
			roll_q          <= '0;
			pitch_q         <= '0;
			yaw_q           <= '0;
			ov_q            <= 1'b0;
			dv_axis_q       <= '0;
			dv_cnt_q        <= '0;
			hk_q            <= '0;
			kk_q            <= '0;
			qs_q            <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					imuca_pkg::REG_SAMPLE_PERIOD: sample_period_q <= cfg_wdata;
					imuca_pkg::REG_BLEND_ALPHA:   blend_alpha_q   <= cfg_wdata[16:0];
					imuca_pkg::REG_CALIB_COUNT:   calib_count_q   <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			// the output state handles its own transfer
			if (ov_q && attitude_out.ready && state_q != S_QOUT)
				ov_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (sample_in.valid) begin
						ax_q <= sample_in.accel_x;
						ay_q <= sample_in.accel_y;
						az_q <= sample_in.accel_z;
						gx_q <= 19'(sample_in.gyro_x) - 19'(bias_x_q);
						gy_q <= 19'(sample_in.gyro_y) - 19'(bias_y_q);
						gz_q <= 19'(sample_in.gyro_z) - 19'(bias_z_q);
						if (!ready_q) begin
							// calibration sample: accumulate, no transfer out
							bias_sum_x_q <= bias_sum_x_q + 34'(sample_in.gyro_x);
							bias_sum_y_q <= bias_sum_y_q + 34'(sample_in.gyro_y);
							bias_sum_z_q <= bias_sum_z_q + 34'(sample_in.gyro_z);
							calib_seen_q <= seen_nx[15:0];
							if (seen_nx >= lim) begin
								dv_axis_q <= '0;
								state_q   <= S_CAL_LOAD;
							end
						end else begin
							state_q <= S_SQ_A;
						end
					end
				end

				// bias = sum / seen, truncated toward zero, one quotient bit a cycle
				S_CAL_LOAD: begin
					logic signed [33:0] sum;
					case (dv_axis_q)
						2'd0: sum = bias_sum_x_q;
						2'd1: sum = bias_sum_y_q;
						default: sum = bias_sum_z_q;
					endcase
					dv_neg_q <= sum < 0;
					quo_q    <= (sum < 0) ? 34'(-sum) : 34'(sum);
					rem_q    <= '0;
					dv_cnt_q <= 6'd33;
					state_q  <= S_CAL_DIV;
				end
				S_CAL_DIV: begin
					if (dv_t >= {1'b0, calib_seen_q}) begin
						rem_q <= dv_t - {1'b0, calib_seen_q};
						quo_q <= {quo_q[32:0], 1'b1};
					end else begin
						rem_q <= dv_t;
						quo_q <= {quo_q[32:0], 1'b0};
					end
					dv_cnt_q <= dv_cnt_q - 6'd1;
					if (dv_cnt_q == '0)
						state_q <= S_CAL_STORE;
				end
				S_CAL_STORE: begin
					logic [33:0] q;
					q = dv_neg_q ? -quo_q : quo_q;
					case (dv_axis_q)
						2'd0: bias_x_q <= q[17:0];
						2'd1: bias_y_q <= q[17:0];
						default: bias_z_q <= q[17:0];
					endcase
					if (dv_axis_q == 2'd2) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						dv_axis_q <= dv_axis_q + 2'd1;
						state_q   <= S_CAL_LOAD;
					end
				end

				// accel norm: floor sqrt of (ay^2 + az^2) * 2^32
				S_SQ_A: state_q <= S_SQ_B;
				S_SQ_B: begin
					sq_q    <= prod_q[31:0];
					state_q <= S_SQ_C;
				end
				S_SQ_C: begin
					rad_q    <= {sq_q + prod_q[31:0], 32'd0};
					srem_q   <= '0;
					root_q   <= '0;
					dv_cnt_q <= 6'd31;
					state_q  <= S_SQRT;
				end
				S_SQRT: begin
					if (s_t >= s_trial) begin
						srem_q <= s_t - s_trial;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						srem_q <= s_t;
						root_q <= {root_q[30:0], 1'b0};
					end
					rad_q    <= {rad_q[61:0], 2'b00};
					dv_cnt_q <= dv_cnt_q - 6'd1;
					if (dv_cnt_q == '0)
						state_q <= S_ROLL_GO;
				end

				// accelerometer roll and pitch by cordic vectoring
				S_ROLL_GO: begin
					if (at_zero) begin
						r_acc_q <= '0;
						state_q <= S_PIT_GO;
					end else begin
						state_q <= S_ROLL_WAIT;
					end
				end
				S_ROLL_WAIT: begin
					if (cdone) begin
						r_acc_q <= AW'((cz + (36'sd1 <<< (ASH - 1))) >>> ASH);
						state_q <= S_PIT_GO;
					end
				end
				S_PIT_GO: begin
					if (at_zero) begin
						p_acc_q <= '0;
						state_q <= S_INT_X;
					end else begin
						state_q <= S_PIT_WAIT;
					end
				end
				S_PIT_WAIT: begin
					if (cdone) begin
						p_acc_q <= AW'((cz + (36'sd1 <<< (ASH - 1))) >>> ASH);
						state_q <= S_INT_X;
					end
				end

				// gyro integration
				S_INT_X: state_q <= S_INT_Y;
				S_INT_Y: begin
					rg_q    <= AW'(roll_q) + inc_w[AW-1:0];
					state_q <= S_INT_Z;
				end
				S_INT_Z: begin
					pg_q    <= AW'(pitch_q) + inc_w[AW-1:0];
					state_q <= S_INT_W;
				end
				S_INT_W: begin
					yw_q    <= AW'(yaw_q) + inc_w[AW-1:0];
					state_q <= S_BR1;
				end

				// complementary blend, yaw wrap alongside
				S_BR1: begin
					yaw_q   <= sat24(68'(yw2));
					state_q <= S_BR2;
				end
				S_BR2: begin
					acc_q   <= prod_q;
					state_q <= S_BR3;
				end
				S_BR3: begin
					roll_q  <= sat24(blend_w);
					state_q <= S_BP1;
				end
				S_BP1: state_q <= S_BP2;
				S_BP2: begin
					acc_q   <= prod_q;
					state_q <= S_BP3;
				end
				S_BP3: begin
					pitch_q <= sat24(blend_w);
					hk_q    <= '0;
					state_q <= S_HS_LOAD;
				end

				// cos and sin of half roll, pitch and yaw
				S_HS_LOAD: begin
					mneg_q  <= hs_v < 0;
					mag_q   <= (hs_v < 0) ? MW'(-hs_v) : MW'(hs_v);
					kk_q    <= 4'(imuca_pkg::MODK);
					state_q <= S_HS_MOD;
				end
				S_HS_MOD: begin
					if (mag_q >= mod_sub)
						mag_q <= mag_q - mod_sub;
					kk_q <= kk_q - 4'd1;
					if (kk_q == '0)
						state_q <= S_HS_GO;
				end
				S_HS_GO: begin
					hneg_q  <= hfold;
					state_q <= S_HS_WAIT;
				end
				S_HS_WAIT: begin
					if (cdone) begin
						c_q[hk_q] <= hneg_q ? -cx[PW-1:0] : cx[PW-1:0];
						s_q[hk_q] <= hneg_q ? -cy[PW-1:0] : cy[PW-1:0];
						if (hk_q == 2'd2) begin
							qs_q    <= '0;
							state_q <= S_QM;
						end else begin
							hk_q    <= hk_q + 2'd1;
							state_q <= S_HS_LOAD;
						end
					end
				end

				// twelve rounded q30 products, one a cycle
				S_QM: begin
					if (qs_q != '0)
						t_q[qs_q - 4'd1] <= mq_w[PW-1:0];
					qs_q <= qs_q + 4'd1;
					if (qs_q == 4'd12)
						state_q <= S_QOUT;
				end

				S_QOUT: begin
					if (!ov_q || attitude_out.ready) begin
						ov_q <= 1'b1;
						attitude_out.quat_x <= qx_o;
						attitude_out.quat_y <= qy_o;
						attitude_out.quat_z <= qz_o;
						attitude_out.quat_w <= qw_o;
						attitude_out.rate_x <= gx_q;
						attitude_out.rate_y <= gy_q;
						attitude_out.rate_z <= gz_q;
						attitude_out.lin_x  <= ax_q;
						attitude_out.lin_y  <= ay_q;
						attitude_out.lin_z  <= az_q;
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign attitude_out.valid = ov_q;

endmodule

FILE: src/imuca_cordic.sv
// ----------------------------------------------------------------------------
// imuca_cordic
// Iterative cordic, one micro-rotation a cycle, vectoring or rotating.
// ----------------------------------------------------------------------------
module imuca_cordic #(
	parameter int STEPS = imuca_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  imuca_pkg::cordic_cmd_t cmd,
	input  logic signed [imuca_pkg::CW-1:0] x0,
	input  logic signed [imuca_pkg::CW-1:0] y0,
	input  logic signed [imuca_pkg::ZW-1:0] z0,
	output logic signed [imuca_pkg::CW-1:0] x,
	output logic signed [imuca_pkg::CW-1:0] y,
	output logic signed [imuca_pkg::ZW-1:0] z,
	output logic done
);
	localparam int NS = (STEPS > 24) ? 24 : STEPS;

	logic signed [imuca_pkg::CW-1:0] x_q, y_q, sx, sy;
	logic signed [imuca_pkg::ZW-1:0] z_q, at;
	logic [4:0] i_q;
	logic busy_q, rot_q, done_q, up;

	assign sx = x_q >>> i_q;
	assign sy = y_q >>> i_q;
	assign at = imuca_pkg::atan_q30(i_q);
	// rotating with a non-negative residue and vectoring with y below zero turn the same way
	assign up = rot_q ? (z_q >= 0) : (y_q < 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rot_q  <= 1'b0;
			i_q    <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			rot_q  <= cmd.rotate;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 5'd1;
			if (i_q == 5'(NS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + at;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
	assign done = done_q;
endmodule
